// ===== hw/rtl/pit_pkg.sv =====
// Shared constants for the point-in-triangle area test.
`default_nettype none
package pit_pkg;
	localparam int COORD_BITS_DEF = 16;
	localparam int TOL_BITS       = 16;
	localparam logic [TOL_BITS-1:0] TOL_RESET = 16'd6554;
endpackage
`default_nettype wire

// ===== hw/rtl/point_in_triangle_area_test_unit.sv =====
// Top level: 3D point-in-triangle test by comparison of areas.
//
//  channel   ports                                  handshake
//  request   start, busy, point_*, first_*, ...     start & !busy
//  result    done, inside_res, degenerate           done, one cycle
//  config    tol_we, tol_wdata                      tol_we
//
// One request per cycle; busy is always low. A request passes through the
// cross-product stages, the one-bit-per-stage square root and the compare
// stages. Reset clears valid bits and sets the tolerance to 6554. The
// receiver cannot stall, so the pipeline never holds.
`default_nettype none
module point_in_triangle_area_test_unit import pit_pkg::*; #(
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         start,
	output logic                              busy,
	input  wire logic signed [COORD_BITS-1:0] point_x, point_y, point_z,
	input  wire logic signed [COORD_BITS-1:0] first_x, first_y, first_z,
	input  wire logic signed [COORD_BITS-1:0] second_x, second_y, second_z,
	input  wire logic signed [COORD_BITS-1:0] third_x, third_y, third_z,
	input  wire logic                         tol_we,
	input  wire logic [TOL_BITS-1:0]          tol_wdata,
	output logic                              done,
	output logic                              inside_res,
	output logic                              degenerate
);
	localparam int SW = 4*COORD_BITS + 6;
	localparam int RW = SW / 2;
	localparam int SS = RW + 2;
	localparam int PW = SS + TOL_BITS;

	logic [TOL_BITS-1:0] tol_q;
	logic                req;
	logic [3:0]          cv;
	logic [SW-1:0]       sq [4];
	logic [3:0]          rv;
	logic [RW-1:0]       rt [4];

	logic          v_s7, v_s8, v_s9, v_s10;
	logic [SS-1:0] s_s7, a_s7;
	logic [SS-1:0] diff_s8, big_s8;
	logic          deg_s8, deg_s9;
	logic [PW-1:0] lhs_s9, rhs_s9;
	logic          inside_s10, deg_s10;

	assign busy = 1'b0;
	assign req  = start & ~busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_q <= TOL_RESET;
		end else if (tol_we) begin
			tol_q <= tol_wdata;
		end
	end

	// full, alpha (P,V2,V3), beta (P,V3,V1), gamma (P,V1,V2)
	pit_cross #(.COORD_BITS(COORD_BITS)) u_full (
		.clk, .arst_n, .in_valid(req),
		.ax(first_x), .ay(first_y), .az(first_z),
		.bx(second_x), .by(second_y), .bz(second_z),
		.cx(third_x), .cy(third_y), .cz(third_z),
		.out_valid(cv[0]), .out_sq(sq[0]));
	pit_cross #(.COORD_BITS(COORD_BITS)) u_alpha (
		.clk, .arst_n, .in_valid(req),
		.ax(point_x), .ay(point_y), .az(point_z),
		.bx(second_x), .by(second_y), .bz(second_z),
		.cx(third_x), .cy(third_y), .cz(third_z),
		.out_valid(cv[1]), .out_sq(sq[1]));
	pit_cross #(.COORD_BITS(COORD_BITS)) u_beta (
		.clk, .arst_n, .in_valid(req),
		.ax(point_x), .ay(point_y), .az(point_z),
		.bx(third_x), .by(third_y), .bz(third_z),
		.cx(first_x), .cy(first_y), .cz(first_z),
		.out_valid(cv[2]), .out_sq(sq[2]));
	pit_cross #(.COORD_BITS(COORD_BITS)) u_gamma (
		.clk, .arst_n, .in_valid(req),
		.ax(point_x), .ay(point_y), .az(point_z),
		.bx(first_x), .by(first_y), .bz(first_z),
		.cx(second_x), .cy(second_y), .cz(second_z),
		.out_valid(cv[3]), .out_sq(sq[3]));

	for (genvar i = 0; i < 4; i++) begin : g_sqrt
		pit_isqrt #(.W(SW)) u_sqrt (
			.clk, .arst_n, .in_valid(cv[i]), .in_n(sq[i]),
			.out_valid(rv[i]), .out_root(rt[i]));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s7  <= 1'b0;
			v_s8  <= 1'b0;
			v_s9  <= 1'b0;
			v_s10 <= 1'b0;
		end else begin
			v_s7  <= rv[0] & rv[1] & rv[2] & rv[3];
			v_s8  <= v_s7;
			v_s9  <= v_s8;
			v_s10 <= v_s9;
		end
	end

	always_ff @(posedge clk) begin
		s_s7    <= SS'(rt[1]) + SS'(rt[2]) + SS'(rt[3]);
		a_s7    <= SS'(rt[0]);
		diff_s8 <= (s_s7 >= a_s7) ? s_s7 - a_s7 : a_s7 - s_s7;
		big_s8  <= (s_s7 >= a_s7) ? s_s7 : a_s7;
		deg_s8  <= (a_s7 == '0);
		lhs_s9  <= {diff_s8, {TOL_BITS{1'b0}}};
		rhs_s9  <= PW'(big_s8) * PW'(tol_q);
		deg_s9  <= deg_s8;
		inside_s10 <= ~deg_s9 & (lhs_s9 <= rhs_s9);
		deg_s10    <= deg_s9;
	end

	assign done       = v_s10;
	assign inside_res = inside_s10;
	assign degenerate = deg_s10;
endmodule
`default_nettype wire

// ===== hw/rtl/pit_cross.sv =====
// Squared length of (b-a) x (c-a), six register stages.
`default_nettype none
module pit_cross import pit_pkg::*; #(
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         in_valid,
	input  wire logic signed [COORD_BITS-1:0] ax, ay, az,
	input  wire logic signed [COORD_BITS-1:0] bx, by, bz,
	input  wire logic signed [COORD_BITS-1:0] cx, cy, cz,
	output logic                              out_valid,
	output logic [4*COORD_BITS+5:0]           out_sq
);
	localparam int D = COORD_BITS + 1;
	localparam int P = 2*COORD_BITS + 2;
	localparam int X = 2*COORD_BITS + 3;
	localparam int M = 2*COORD_BITS + 2;
	localparam int Q = 2*M;
	localparam int SW = 4*COORD_BITS + 6;

	logic [5:0] vld_q;
	logic signed [D-1:0] e_s1 [3];
	logic signed [D-1:0] f_s1 [3];
	logic signed [P-1:0] p_s2 [6];
	logic signed [X-1:0] x_s3 [3];
	logic [M-1:0] m_s4 [3];
	logic [Q-1:0] q_s5 [3];
	logic [SW-1:0] sum_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[4:0], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		e_s1[0] <= D'(bx) - D'(ax);
		e_s1[1] <= D'(by) - D'(ay);
		e_s1[2] <= D'(bz) - D'(az);
		f_s1[0] <= D'(cx) - D'(ax);
		f_s1[1] <= D'(cy) - D'(ay);
		f_s1[2] <= D'(cz) - D'(az);
		p_s2[0] <= P'(e_s1[1]) * P'(f_s1[2]);
		p_s2[1] <= P'(e_s1[2]) * P'(f_s1[1]);
		p_s2[2] <= P'(e_s1[2]) * P'(f_s1[0]);
		p_s2[3] <= P'(e_s1[0]) * P'(f_s1[2]);
		p_s2[4] <= P'(e_s1[0]) * P'(f_s1[1]);
		p_s2[5] <= P'(e_s1[1]) * P'(f_s1[0]);
		for (int i = 0; i < 3; i++) begin
			x_s3[i] <= X'(p_s2[2*i]) - X'(p_s2[2*i+1]);
			m_s4[i] <= x_s3[i][X-1] ? M'(-x_s3[i]) : M'(x_s3[i]);
			q_s5[i] <= Q'(m_s4[i]) * Q'(m_s4[i]);
		end
		sum_s6 <= SW'(q_s5[0]) + SW'(q_s5[1]) + SW'(q_s5[2]);
	end

	assign out_valid = vld_q[5];
	assign out_sq    = sum_s6;
endmodule
`default_nettype wire

// ===== hw/rtl/pit_isqrt.sv =====
// Pipelined floor square root, one result bit per stage.
`default_nettype none
module pit_isqrt import pit_pkg::*; #(
	parameter int W = 4*COORD_BITS_DEF + 6
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	input  wire logic [W-1:0]     in_n,
	output logic                  out_valid,
	output logic [W/2-1:0]        out_root
);
	localparam int H = W / 2;
	localparam int RM = H + 2;

	logic [RM-1:0] rem_s  [H+1];
	logic [H-1:0]  root_s [H+1];
	logic [W-1:0]  n_s    [H+1];
	logic [H:0]    vld_s;

	always_comb begin
		rem_s[0]  = '0;
		root_s[0] = '0;
		n_s[0]    = in_n;
		vld_s[0]  = in_valid;
	end

	for (genvar k = 0; k < H; k++) begin : g_stage
		logic [RM-1:0] rem2;
		logic [RM-1:0] trial;
		logic          take;
		always_comb begin
			rem2  = {rem_s[k][RM-3:0], n_s[k][W-1:W-2]};
			trial = {root_s[k], 2'b01};
			take  = rem2 >= trial;
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else begin
				vld_s[k+1] <= vld_s[k];
			end
		end
		always_ff @(posedge clk) begin
			rem_s[k+1]  <= take ? rem2 - trial : rem2;
			root_s[k+1] <= {root_s[k][H-2:0], take};
			n_s[k+1]    <= {n_s[k][W-3:0], 2'b00};
		end
	end

	assign out_valid = vld_s[H];
	assign out_root  = root_s[H];
endmodule
`default_nettype wire

// ===== dv/pit_checker.sv =====
// Checker: predicts the inside/degenerate result of each request and compares.
module pit_checker import pit_pkg::*; #(
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         start,
	input  wire logic                         busy,
	input  wire logic signed [COORD_BITS-1:0] point_x, point_y, point_z,
	input  wire logic signed [COORD_BITS-1:0] first_x, first_y, first_z,
	input  wire logic signed [COORD_BITS-1:0] second_x, second_y, second_z,
	input  wire logic signed [COORD_BITS-1:0] third_x, third_y, third_z,
	input  wire logic                         tol_we,
	input  wire logic [TOL_BITS-1:0]          tol_wdata,
	input  wire logic                         done,
	input  wire logic                         inside_res,
	input  wire logic                         degenerate,
	output int                                errors,
	output int                                pending,
	output int                                n_inside,
	output int                                n_degen
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic in_tri;
		logic degen;
	} verdict_t;

	typedef logic signed [63:0] s64_t;

	verdict_t            verdicts[$];
	logic [TOL_BITS-1:0] tol;

	function automatic logic [63:0] floor_sqrt(logic [127:0] n);
		logic [63:0]  r;
		logic [63:0]  c;
		r = '0;
		for (int b = 63; b >= 0; b--) begin
			c = r | (64'd1 << b);
			if (128'(c) * 128'(c) <= n)
				r = c;
		end
		return r;
	endfunction

	// twice the triangle area, floored
	function automatic logic [63:0] tri_area(s64_t ax, s64_t ay, s64_t az, s64_t bx,
			s64_t by, s64_t bz, s64_t cx, s64_t cy, s64_t cz);
		s64_t         ex, ey, ez, fx, fy, fz, x0, x1, x2;
		logic [127:0] m0, m1, m2, sq;
		ex = bx - ax; ey = by - ay; ez = bz - az;
		fx = cx - ax; fy = cy - ay; fz = cz - az;
		x0 = ey * fz - ez * fy;
		x1 = ez * fx - ex * fz;
		x2 = ex * fy - ey * fx;
		// squares exceed 64 bits, so square the magnitudes at full width
		m0 = 128'(x0 < 0 ? -x0 : x0);
		m1 = 128'(x1 < 0 ? -x1 : x1);
		m2 = 128'(x2 < 0 ? -x2 : x2);
		sq = m0 * m0 + m1 * m1 + m2 * m2;
		return floor_sqrt(sq);
	endfunction

	function automatic verdict_t classify();
		verdict_t     v;
		logic [63:0]  full, s, diff, big;
		s64_t         px, py, pz, ax, ay, az, bx, by, bz, cx, cy, cz;
		px = point_x; py = point_y; pz = point_z;
		ax = first_x; ay = first_y; az = first_z;
		bx = second_x; by = second_y; bz = second_z;
		cx = third_x; cy = third_y; cz = third_z;
		full = tri_area(ax, ay, az, bx, by, bz, cx, cy, cz);
		v = '0;
		if (full == 0) begin
			v.degen = 1'b1;
			return v;
		end
		s = tri_area(px, py, pz, bx, by, bz, cx, cy, cz)
			+ tri_area(px, py, pz, cx, cy, cz, ax, ay, az)
			+ tri_area(px, py, pz, ax, ay, az, bx, by, bz);
		diff = s >= full ? s - full : full - s;
		big  = s >= full ? s : full;
		v.in_tri = (128'(diff) * 128'd65536) <= (128'(big) * 128'(tol));
		return v;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		verdict_t want;
		int       nerr;
		if (!arst_n) begin
			tol      <= TOL_RESET;
			errors   <= 0;
			pending  <= 0;
			n_inside <= 0;
			n_degen  <= 0;
			verdicts.delete();
		end else begin
			nerr = 0;
			if (done) begin
				if (verdicts.size() == 0) begin
					$error("result with no request outstanding");
					nerr++;
				end else begin
					want = verdicts.pop_front();
					if (inside_res !== want.in_tri) begin
						$error("inside_res: expected %0b, got %0b", want.in_tri, inside_res);
						nerr++;
					end
					if (degenerate !== want.degen) begin
						$error("degenerate: expected %0b, got %0b", want.degen, degenerate);
						nerr++;
					end
					n_inside <= n_inside + want.in_tri;
					n_degen  <= n_degen + want.degen;
				end
			end
			if (start && !busy)
				verdicts.push_back(classify());
			if (tol_we)
				tol <= tol_wdata;
			errors  <= errors + nerr;
			pending <= verdicts.size();
		end
	end
endmodule

// ===== dv/tb_point_in_triangle_area_test_unit.sv =====
// Testbench top: drives requests and tolerance writes, reports the verdict.
module tb_point_in_triangle_area_test_unit;
	import pit_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CB      = COORD_BITS_DEF;
	localparam int LATENCY = 6 + (2 * CB + 3) + 4;
	localparam int N_RAND  = 1800;

	typedef logic signed [CB-1:0] crd_t;

	logic                clk, arst_n, start, busy, tol_we, done, inside_res, degenerate;
	logic [TOL_BITS-1:0] tol_wdata;
	crd_t                c[12];
	int                  errors, pending, n_inside, n_degen, n_sent;

	point_in_triangle_area_test_unit #(.COORD_BITS(CB)) uut (
		.clk, .arst_n, .start, .busy,
		.point_x(c[0]), .point_y(c[1]), .point_z(c[2]),
		.first_x(c[3]), .first_y(c[4]), .first_z(c[5]),
		.second_x(c[6]), .second_y(c[7]), .second_z(c[8]),
		.third_x(c[9]), .third_y(c[10]), .third_z(c[11]),
		.tol_we, .tol_wdata, .done, .inside_res, .degenerate
	);

	pit_checker #(.COORD_BITS(CB)) chk (
		.clk, .arst_n, .start, .busy,
		.point_x(c[0]), .point_y(c[1]), .point_z(c[2]),
		.first_x(c[3]), .first_y(c[4]), .first_z(c[5]),
		.second_x(c[6]), .second_y(c[7]), .second_z(c[8]),
		.third_x(c[9]), .third_y(c[10]), .third_z(c[11]),
		.tol_we, .tol_wdata, .done, .inside_res, .degenerate,
		.errors, .pending, .n_inside, .n_degen
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#20ms;
		$display("Simulation FAILED");
		$finish;
	end

	// one request, called at a falling edge; start stays high so requests can follow
	task automatic send(input crd_t v[12]);
		c     = v;
		start <= 1'b1;
		@(posedge clk);
		while (busy) @(posedge clk);
		n_sent++;
		@(negedge clk);
	endtask

	// drain everything, then pass the pipeline latency, then write
	task automatic set_tol(input logic [TOL_BITS-1:0] t);
		start <= 1'b0;
		@(negedge clk);
		while (pending != 0) @(negedge clk);
		repeat (LATENCY + 4) @(negedge clk);
		tol_we    <= 1'b1;
		tol_wdata <= t;
		@(negedge clk);
		tol_we    <= 1'b0;
	endtask

	function automatic crd_t rnd_coord(int mode);
		case (mode)
			0: return crd_t'($urandom);
			1: return crd_t'($urandom_range(0, 64) - 32);
			default: return crd_t'($urandom_range(0, 2000) - 1000);
		endcase
	endfunction

	// random triangle; point often a blend of the vertices
	function automatic void make_item(output crd_t v[12]);
		int   mode, w1, w2, w3, kind;
		mode = $urandom_range(0, 2);
		for (int i = 3; i < 12; i++) v[i] = rnd_coord(mode);
		kind = $urandom_range(0, 9);
		if (kind == 0) begin
			for (int i = 0; i < 3; i++) v[9 + i] = v[6 + i];
		end else if (kind == 1) begin
			for (int i = 0; i < 3; i++) v[9 + i] = crd_t'(2 * v[6 + i] - v[3 + i]);
		end
		if (kind < 5 && mode != 0) begin
			w1 = $urandom_range(0, 100); w2 = $urandom_range(0, 100 - w1);
			w3 = 100 - w1 - w2;
			for (int i = 0; i < 3; i++)
				v[i] = crd_t'((w1 * v[3 + i] + w2 * v[6 + i] + w3 * v[9 + i]) / 100
					+ int'($urandom_range(0, 2)) - 1);
		end else begin
			for (int i = 0; i < 3; i++) v[i] = rnd_coord(mode);
		end
	endfunction

	initial begin
		crd_t v[12];
		int   burst;
		logic [TOL_BITS-1:0] tols[4];
		tols = '{16'd0, 16'hFFFF, 16'd655, 16'd6554};
		start = 1'b0; tol_we = 1'b0; tol_wdata = '0; n_sent = 0;
		foreach (c[i]) c[i] = '0;
		arst_n = 1'b0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: degenerate cases, extremes, simple inside/outside
		foreach (v[i]) v[i] = '0;
		send(v);
		foreach (v[i]) v[i] = crd_t'(1 << (CB - 1));
		send(v);
		foreach (v[i]) v[i] = crd_t'((1 << (CB - 1)) - 1);
		send(v);
		v = '{0, 0, 0, 0, 0, 0, 100, 0, 0, 0, 100, 0};
		send(v);
		v = '{20, 20, 0, 0, 0, 0, 100, 0, 0, 0, 100, 0};
		send(v);
		v = '{200, 200, 5, 0, 0, 0, 100, 0, 0, 0, 100, 0};
		send(v);
		v = '{-32768, 32767, -32768, -32768, -32768, -32768, 32767, -32768, 32767,
			-32768, 32767, 32767};
		send(v);
		v = '{32767, 32767, 32767, 32767, -32768, 32767, -32768, 32767, -32768,
			32767, 32767, -32768};
		send(v);
		v = '{-1, -1, -1, 0, 0, 0, 1, 1, 1, 2, 2, 2};
		send(v);
		v = '{30, 30, 0, 0, 0, 0, 0, 0, 0, 50, 50, 0};
		send(v);
		for (int i = 0; i < 12; i++) begin
			foreach (v[k]) v[k] = crd_t'($urandom);
			v[i] = (i % 2) ? crd_t'(1 << (CB - 1)) : crd_t'((1 << (CB - 1)) - 1);
			send(v);
		end

		for (int phase = 0; phase < 4; phase++) begin
			set_tol(tols[phase]);
			for (int n = 0; n < N_RAND / 4;) begin
				burst = $urandom_range(1, 40);
				for (int b = 0; b < burst && n < N_RAND / 4; b++, n++) begin
					make_item(v);
					send(v);
				end
				if ($urandom_range(0, 3) == 0 || (n > 100 && n < 140)) begin
					start <= 1'b0;
					repeat ($urandom_range(1, 12)) @(negedge clk);
					if (n > 100 && n < 140)
						while (pending != 0) @(negedge clk);
				end
			end
		end

		@(negedge clk);
		start <= 1'b0;
		@(negedge clk);
		while (pending != 0) @(negedge clk);
		repeat (LATENCY + 10) @(negedge clk);
		$display("Sent %0d requests over four tolerance settings (zero, max, 0.01, 0.1).",
			n_sent);
		$display("Results: %0d inside, %0d degenerate triangles.", n_inside, n_degen);
		if (errors == 0 && pending == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end
endmodule
